/* design/kerk_pkg.sv */
package kerk_pkg;

    localparam int KEY_W  = 16;
    localparam int RANK_W = 17;
    localparam int ENT_W  = KEY_W + RANK_W;

    localparam logic [RANK_W-1:0] RANK_ONE = 17'h10000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic              prefer_highest;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] kept_key;
        logic             has_key;
        logic             last;
        logic             dropped;
    } result_t;

    // compare unit outcome
    typedef struct packed {
        logic take;
        logic equal;
    } cmp_t;

endpackage

/* design/kerk_ram.sv */
module kerk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/kerk_rank_unit.sv */
module kerk_rank_unit (
    input  logic [kerk_pkg::RANK_W-1:0] rank,
    input  logic [kerk_pkg::RANK_W-1:0] best,
    input  logic                        highest,
    output kerk_pkg::cmp_t              res
);

    import kerk_pkg::*;

    // ties take over the extreme in both modes
    always_comb
    begin
        res.take  = highest ? (best <= rank) : (best >= rank);
        res.equal = (rank == best);
    end

endmodule

/* design/keep_extreme_ranked_keys_core.sv */
// Collects up to MAX_CANDIDATES (key, rank) candidates, one load beat per cycle;
// loads that find the list full are discarded and reported through dropped.
// A run beat keeps only the entries holding the highest (or lowest) rank and
// emits their keys in compacted order, last marking the final beat, or one
// beat with has_key low when nothing survives; the list is then cleared.
// All work goes through one single-port-write, registered-read list memory
// and one shared rank comparator, so a run scans every entry to find the
// extreme, then compacts the list by checking each entry and moving the tail
// entry over each removed one, then reads each kept entry to emit it. The
// block takes no beat while a run is in progress.
module keep_extreme_ranked_keys_core #(
    parameter int MAX_CANDIDATES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  kerk_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output kerk_pkg::result_t result
);

    import kerk_pkg::*;

    localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_CANDIDATES);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_FIND    = 8'b00000010,
        S_CHK     = 8'b00000100,
        S_CHK_D   = 8'b00001000,
        S_MOVE    = 8'b00010000,
        S_EMIT_RD = 8'b00100000,
        S_EMIT_LD = 8'b01000000,
        S_EMPTY   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pend_reg, pend_next;
    logic          rvalid_reg, rvalid_next;
    logic [RANK_W-1:0] best_reg, best_next;
    logic          mode_reg, mode_next;
    result_t       res_reg, res_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic [RANK_W-1:0] rd_rank;
    logic [KEY_W-1:0]  rd_key;
    logic [CW-1:0]     n_dec;
    logic              out_free;
    cmp_t              cmp;

    assign rd_rank  = ram_rdata[RANK_W-1:0];
    assign rd_key   = ram_rdata[ENT_W-1 -: KEY_W];
    assign n_dec    = n_reg - CW'(1);
    assign out_free = !rvalid_reg || result_ready;

    kerk_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kerk_rank_unit u_cmp (
        .rank    (rd_rank),
        .best    (best_reg),
        .highest (mode_reg),
        .res     (cmp)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        n_next      = n_reg;
        a_next      = a_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pend_next   = pend_reg;
        best_next   = best_reg;
        mode_next   = mode_reg;
        res_next    = res_reg;
        rvalid_next = rvalid_reg && !result_ready;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = {item.key, item.rank};
        ram_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.kind == KIND_LOAD)
                    begin
                        if (count_reg < CAP)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next  = item.prefer_highest;
                        best_next  = item.prefer_highest ? '0 : RANK_ONE;
                        n_next     = count_reg;
                        a_next     = '0;
                        i_next     = '0;
                        pend_next  = 1'b0;
                        state_next = (count_reg == '0) ? S_EMPTY : S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (pend_reg && cmp.take)
                begin
                    best_next = rd_rank;
                end
                if (a_reg != n_reg)
                begin
                    ram_raddr = a_reg[AW-1:0];
                    a_next    = a_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (i_reg == n_reg)
                begin
                    j_next     = '0;
                    state_next = (n_reg == '0) ? S_EMPTY : S_EMIT_RD;
                end
                else
                begin
                    ram_raddr  = i_reg[AW-1:0];
                    state_next = S_CHK_D;
                end
            end
            S_CHK_D:
            begin
                if (cmp.equal)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CHK;
                end
                else
                begin
                    ram_raddr  = n_dec[AW-1:0];
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // tail entry overwrites the rejected one
                ram_we     = 1'b1;
                ram_waddr  = i_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                n_next     = n_dec;
                state_next = S_CHK;
            end
            S_EMIT_RD:
            begin
                if (out_free)
                begin
                    ram_raddr  = j_reg[AW-1:0];
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                res_next.kept_key = rd_key;
                res_next.has_key  = 1'b1;
                res_next.last     = (j_reg == n_dec);
                res_next.dropped  = ovf_reg;
                rvalid_next       = 1'b1;
                if (j_reg == n_dec)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_EMIT_RD;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    res_next.kept_key = '0;
                    res_next.has_key  = 1'b0;
                    res_next.last     = 1'b1;
                    res_next.dropped  = ovf_reg;
                    rvalid_next       = 1'b1;
                    count_next        = '0;
                    ovf_next          = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            n_reg      <= '0;
            a_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            pend_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            n_reg      <= n_next;
            a_reg      <= a_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            pend_reg   <= pend_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        mode_reg <= mode_next;
        res_reg  <= res_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = res_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("entry count above capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CAP))
        else $error("overflow flagged with room in the list");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && !res_reg.has_key) |-> res_reg.last)
        else $error("empty result not marked last");

    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg <= count_reg && i_reg <= n_reg))
        else $error("compaction pointers out of range");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && j_reg == n_dec) |=> (state_reg == S_IDLE))
        else $error("run did not finish after last beat");

endmodule
